FILE: rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted max-priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam int CAPACITY = 32;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int PRI_W    = 16;
   localparam int PAY_W    = 32;
   localparam int MODE_W   = 2;
   localparam int STAT_W   = 2;
   localparam int OCC_W    = 6;

   typedef enum logic [MODE_W-1:0] {
      MODE_INSERT  = 2'd0,
      MODE_EXTRACT = 2'd1,
      MODE_PEEK    = 2'd2,
      MODE_NOP     = 2'd3
   } mode_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_DONE  = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      logic signed [PRI_W-1:0] pri;
      logic        [PAY_W-1:0] pay;
   } spq_entry_type;

   // per-cycle command broadcast to every cell
   typedef struct packed {
      logic          insert;
      logic          extract;
      spq_entry_type new_entry;
   } spq_cmd_type;

endpackage

FILE: rtl/spq_if.sv
// ----------------------------------------------------------------------------
// spq_req_if / spq_rsp_if
// Valid/ready channels for queue commands and queue responses.
// ----------------------------------------------------------------------------
interface spq_req_if import spq_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [MODE_W-1:0]       mode;
   logic signed [PRI_W-1:0] priority_req;
   logic [PAY_W-1:0]        payload;

   modport source (output valid, mode, priority_req, payload, input ready);
   modport sink   (input valid, mode, priority_req, payload, output ready);
endinterface

interface spq_rsp_if import spq_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [STAT_W-1:0]       status;
   logic signed [PRI_W-1:0] out_priority;
   logic [PAY_W-1:0]        out_payload;
   logic [OCC_W-1:0]        occupancy;

   modport source (output valid, status, out_priority, out_payload, occupancy,
                   input ready);
   modport sink   (input valid, status, out_priority, out_payload, occupancy,
                   output ready);
endinterface

FILE: rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted array: holds, takes the new entry, or takes a
// neighbor's entry depending on the command and its local compare.
// ----------------------------------------------------------------------------
module spq_cell import spq_pkg::*; (
   input  logic          clock,
   input  spq_cmd_type   cmd,
   input  logic          occupied,
   input  logic          left_keeps,
   input  spq_entry_type left_entry,
   input  spq_entry_type right_entry,
   output logic          keeps,
   output spq_entry_type entry
);

   spq_entry_type entry_ff;
   spq_entry_type entry_in;

   // stays in place on insert: equal priorities keep arrival order
   assign keeps = occupied && (entry_ff.pri >= cmd.new_entry.pri);

   always_comb begin
      entry_in = entry_ff;
      if (cmd.insert) begin
         if (!keeps) begin
            entry_in = left_keeps ? cmd.new_entry : left_entry;
         end
      end else if (cmd.extract) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

FILE: rtl/sorted_max_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_max_priority_queue
// Bounded max-priority queue kept sorted in a row of slot cells; the head
// sits in cell 0.
//
//   channel   dir   handshake          payload
//   req_chan  in    valid / ready      mode, priority_req, payload
//   rsp_chan  out   valid / ready      status, out_priority, out_payload, occupancy
//
// Every operation updates all cells together: all cells compare against the new
// priority in parallel and shift by at most one slot. The response appears
// in the cycle after acceptance, in an output register; a new word is accepted
// whenever that register is empty or being drained. Synchronous reset empties
// the queue; slot contents are not cleared.
// ----------------------------------------------------------------------------
module sorted_max_priority_queue import spq_pkg::*; (
   input logic         clock,
   input logic         reset,
   spq_req_if.sink     req_chan,
   spq_rsp_if.source   rsp_chan
);

   logic [CNT_W-1:0]     count_ff;
   logic [CNT_W-1:0]     count_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   status_type           rsp_status_ff;
   status_type           rsp_status_in;
   spq_entry_type        rsp_entry_ff;
   spq_entry_type        rsp_entry_in;
   logic [OCC_W-1:0]     rsp_occ_ff;
   logic [OCC_W-1:0]     rsp_occ_in;

   logic                 accept;
   logic                 is_full;
   logic                 is_empty;
   spq_cmd_type          cmd;
   spq_entry_type        cell_entry [CAPACITY];
   logic [CAPACITY-1:0]  cell_keeps;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign is_full        = (count_ff == CNT_W'(CAPACITY));
   assign is_empty       = (count_ff == '0);

   always_comb begin
      cmd.insert        = 1'b0;
      cmd.extract       = 1'b0;
      cmd.new_entry.pri = req_chan.priority_req;
      cmd.new_entry.pay = req_chan.payload;
      count_in          = count_ff;
      rsp_status_in     = STAT_DONE;
      rsp_entry_in      = '0;
      if (accept) begin
         unique case (mode_type'(req_chan.mode))
            MODE_INSERT: begin
               if (is_full) begin
                  rsp_status_in = STAT_FULL;
               end else begin
                  cmd.insert = 1'b1;
                  count_in   = count_ff + CNT_W'(1);
               end
            end
            MODE_EXTRACT: begin
               if (is_empty) begin
                  rsp_status_in = STAT_EMPTY;
               end else begin
                  cmd.extract  = 1'b1;
                  count_in     = count_ff - CNT_W'(1);
                  rsp_entry_in = cell_entry[0];
               end
            end
            MODE_PEEK: begin
               if (is_empty) begin
                  rsp_status_in = STAT_EMPTY;
               end else begin
                  rsp_entry_in = cell_entry[0];
               end
            end
            default: begin
               rsp_status_in = STAT_DONE;
            end
         endcase
      end
      rsp_occ_in = OCC_W'(count_in);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic          left_keeps;
      spq_entry_type left_entry;
      spq_entry_type right_entry;

      if (i == 0) begin : g_head
         assign left_keeps = 1'b1;
         assign left_entry = cmd.new_entry;
      end else begin : g_body
         assign left_keeps = cell_keeps[i-1];
         assign left_entry = cell_entry[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign right_entry = cell_entry[i];
      end else begin : g_inner
         assign right_entry = cell_entry[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .occupied    (count_ff > CNT_W'(i)),
         .left_keeps  (left_keeps),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .keeps       (cell_keeps[i]),
         .entry       (cell_entry[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff <= rsp_status_in;
         rsp_entry_ff  <= rsp_entry_in;
         rsp_occ_ff    <= rsp_occ_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.out_priority = rsp_entry_ff.pri;
   assign rsp_chan.out_payload  = rsp_entry_ff.pay;
   assign rsp_chan.occupancy    = rsp_occ_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("stored count above capacity");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      accept && req_chan.mode == MODE_INSERT && !is_full
      |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("insert did not add an entry");

   a_full_keeps: assert property (@(posedge clock) disable iff (reset)
      accept && req_chan.mode == MODE_INSERT && is_full
      |=> count_ff == CNT_W'(CAPACITY) && rsp_status_ff == STAT_FULL)
      else $error("refused insert changed the queue");

   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted word produced no response");

   a_head_sorted: assert property (@(posedge clock) disable iff (reset)
      count_ff > CNT_W'(1) |-> cell_entry[0].pri >= cell_entry[1].pri)
      else $error("head is not the highest priority");
`endif

endmodule
